@@ src/mfre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional divider encoder package
// Widths, register constants, the pipeline word and the write slot codes.
// ----------------------------------------------------------------------------
package mfre_pkg;

    localparam int IDX_W  = 2;
    localparam int DIV_W  = 10;
    localparam int FRAC_W = 20;
    localparam int SCALE_W = 7;
    localparam int Q_W    = FRAC_W + SCALE_W;
    localparam int P1_W   = 18;
    localparam int N_CELLS = Q_W;

    localparam logic [IDX_W-1:0] IDX_MAX = 2'd2;
    localparam logic [DIV_W-1:0] DIV_MIN = 10'd4;
    localparam logic [DIV_W-1:0] DIV_MAX = 10'd900;
    localparam logic [P1_W-1:0]  P1_OFFSET = 18'd512;

    localparam logic [7:0] CTRL_REG_BASE = 8'd16;
    localparam logic [7:0] CTRL_PLLA     = 8'h0F;
    localparam logic [7:0] CTRL_PLLB     = 8'h2F;
    localparam logic [7:0] CTRL_INT_MODE = 8'h40;
    localparam logic [7:0] BASE_OUT0     = 8'd42;
    localparam logic [7:0] BASE_OUT1     = 8'd50;
    localparam logic [7:0] BASE_OUT2     = 8'd58;

    typedef enum logic [3:0] {
        SLOT_P3_HI,
        SLOT_P3_LO,
        SLOT_P1_TOP,
        SLOT_P1_MID,
        SLOT_P1_LO,
        SLOT_MIX,
        SLOT_P2_MID,
        SLOT_P2_LO,
        SLOT_CTRL
    } t_slot;

    // One item as it travels down the divider chain. The word w starts as
    // the scaled numerator and fills with quotient bits from the right.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              pll;
        logic [DIV_W-1:0]  div;
        logic [FRAC_W-1:0] den;
        logic              num_zero;
        logic [Q_W-1:0]    w;
        logic [FRAC_W-1:0] rem;
    } t_cell;

    function automatic logic [7:0] f_base_addr(input logic [IDX_W-1:0] idx);
        logic [7:0] base;
        unique case (idx)
            2'd0:    base = BASE_OUT0;
            2'd1:    base = BASE_OUT1;
            default: base = BASE_OUT2;
        endcase
        return base;
    endfunction

endpackage

@@ src/mfre_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional divider encoder channels
// Request channel carrying one divider setting and write channel carrying
// one register write.
// ----------------------------------------------------------------------------
interface mfre_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  output_index;
    logic        pll_source;
    logic [9:0]  divider;
    logic [19:0] numerator;
    logic [19:0] denominator;

    modport source (output valid, output output_index, output pll_source,
                    output divider, output numerator, output denominator,
                    input ready);
    modport sink   (input valid, input output_index, input pll_source,
                    input divider, input numerator, input denominator,
                    output ready);
endinterface

interface mfre_wr_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       last_write;

    modport source (output valid, output reg_address, output reg_data,
                    output last_write, input ready);
    modport sink   (input valid, input reg_address, input reg_data,
                    input last_write, output ready);
endinterface

@@ src/mfre_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider chain cell
// One restoring division step: shifts in the next dividend bit, subtracts
// the denominator when it fits and appends the quotient bit.
// ----------------------------------------------------------------------------
module mfre_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic           i_valid,
    input  mfre_pkg::t_cell i_data,
    output logic           o_valid,
    output mfre_pkg::t_cell o_data
);
    import mfre_pkg::*;

    logic [FRAC_W:0]   shifted;
    logic [FRAC_W+1:0] diff;
    logic              fits;
    t_cell             n_data;
    logic              r_valid;
    t_cell             r_data;

    always_comb begin
        shifted = {i_data.rem, i_data.w[Q_W-1]};
        diff    = {1'b0, shifted} - {2'b00, i_data.den};
        fits    = ~diff[FRAC_W+1];
        n_data  = i_data;
        n_data.w   = {i_data.w[Q_W-2:0], fits};
        n_data.rem = fits ? diff[FRAC_W-1:0] : shifted[FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/mfre_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register write sequencer
// Holds one finished item and issues its nine register writes through an
// output register.
// ----------------------------------------------------------------------------
module mfre_writer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mfre_pkg::t_cell i_data,
    output logic            o_take,
    mfre_wr_if.source       o_wr
);
    import mfre_pkg::*;

    logic              r_pend;
    t_slot             r_slot;
    logic [IDX_W-1:0]  r_idx;
    logic [7:0]        r_base;
    logic [7:0]        r_ctrl;
    logic [P1_W-1:0]   r_p1;
    logic [FRAC_W-1:0] r_p2;
    logic [FRAC_W-1:0] r_p3;

    logic              r_ov;
    logic [7:0]        r_addr;
    logic [7:0]        r_data;
    logic              r_last;

    logic              load_out;
    logic              take;
    logic [7:0]        n_addr;
    logic [7:0]        n_data;
    logic [P1_W-1:0]   n_p1;
    logic [7:0]        n_ctrl;

    assign load_out = ~r_ov | o_wr.ready;
    assign take     = ~r_pend | (load_out & (r_slot == SLOT_CTRL));
    assign o_take   = take;

    always_comb begin
        n_p1   = {1'b0, i_data.div, {SCALE_W{1'b0}}} + i_data.w[P1_W-1:0] - P1_OFFSET;
        n_ctrl = (i_data.pll ? CTRL_PLLB : CTRL_PLLA)
               | (i_data.num_zero ? CTRL_INT_MODE : 8'h00);
    end

    always_comb begin
        n_addr = r_base + {4'b0000, r_slot};
        unique case (r_slot)
            SLOT_P3_HI:  n_data = r_p3[15:8];
            SLOT_P3_LO:  n_data = r_p3[7:0];
            SLOT_P1_TOP: n_data = {6'b000000, r_p1[17:16]};
            SLOT_P1_MID: n_data = r_p1[15:8];
            SLOT_P1_LO:  n_data = r_p1[7:0];
            SLOT_MIX:    n_data = {r_p3[19:16], r_p2[19:16]};
            SLOT_P2_MID: n_data = r_p2[15:8];
            SLOT_P2_LO:  n_data = r_p2[7:0];
            SLOT_CTRL: begin
                n_data = r_ctrl;
                n_addr = CTRL_REG_BASE + {6'b000000, r_idx};
            end
            default:     n_data = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_slot <= SLOT_P3_HI;
            r_ov   <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov <= r_pend;
            end
            if (take) begin
                r_pend <= i_valid;
                r_slot <= SLOT_P3_HI;
            end else if (load_out) begin
                r_slot <= t_slot'(4'(r_slot) + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_addr <= n_addr;
            r_data <= n_data;
            r_last <= (r_slot == SLOT_CTRL);
        end
        if (take && i_valid) begin
            r_idx  <= i_data.idx;
            r_base <= f_base_addr(i_data.idx);
            r_ctrl <= n_ctrl;
            r_p1   <= n_p1;
            r_p2   <= i_data.rem;
            r_p3   <= i_data.den;
        end
    end

    assign o_wr.valid       = r_ov;
    assign o_wr.reg_address = r_addr;
    assign o_wr.reg_data    = r_data;
    assign o_wr.last_write  = r_last;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (4'(r_slot) <= 4'(SLOT_CTRL)))
        else $error("write slot beyond the control write");

    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> (r_addr >= CTRL_REG_BASE && r_addr <= CTRL_REG_BASE + 8'd2))
        else $error("final write not aimed at a clock-control register");

    a_body_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_last) |-> (r_addr >= BASE_OUT0 && r_addr <= BASE_OUT2 + 8'd7))
        else $error("divider write outside the parameter register block");

endmodule

@@ src/multisynth_fraction_register_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional output divider register encoder
// Encodes an integer divider and a 20-bit fraction into P1, P2, P3 and
// emits the nine register writes that program one clock output.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Word carried                                    Writes per word
//  i_req    in   output_index, pll_source, divider, num, denom   one setting
//  o_wr     out  reg_address, reg_data, last_write               nine per setting
//
// A setting enters a chain of 27 division cells, one quotient bit per cell,
// and then the writer, which issues one write per cycle while o_wr accepts;
// sustained intake is limited by the nine writes through the single output
// register. A new setting is taken every cycle as long as the chain end is
// empty or the writer can take it, being idle or finishing. Reset clears
// all valid flags and the write counter. When o_wr stalls, the chain moves
// on until its end holds a finished setting; then it holds in place and
// i_req.ready drops. Invalid settings are accepted and dropped without
// producing a write.
//
module multisynth_fraction_register_encoder_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfre_req_if.sink  i_req,
    mfre_wr_if.source o_wr
);
    import mfre_pkg::*;

    // Cell k's output lives at index k+1; index 0 is the chain entry.
    logic  c_valid [0:N_CELLS];
    t_cell c_data  [0:N_CELLS];
    logic  item_ok;
    logic  advance;
    logic  take;

    // Range checks on the incoming setting. A numerator above the 20-bit
    // limit cannot be represented, so only the other fields are checked.
    assign item_ok = (i_req.output_index <= IDX_MAX)
                   && (i_req.divider >= DIV_MIN)
                   && (i_req.divider <= DIV_MAX)
                   && (i_req.denominator != '0);

    // The whole chain moves together; it only stops when its final cell
    // holds a result the writer cannot yet take.
    assign advance     = ~c_valid[N_CELLS] | take;
    assign i_req.ready = advance;

    assign c_valid[0] = i_req.valid & item_ok;
    assign c_data[0]  = '{idx:      i_req.output_index,
                          pll:      i_req.pll_source,
                          div:      i_req.divider,
                          den:      i_req.denominator,
                          num_zero: (i_req.numerator == '0),
                          w:        {i_req.numerator, {SCALE_W{1'b0}}},
                          rem:      '0};

    // Each cell resolves one quotient bit of floor(128 * num / denom), most
    // significant first. After the last cell the word holds q and the
    // remainder is P2.
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        mfre_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_valid   (c_valid[k]),
            .i_data    (c_data[k]),
            .o_valid   (c_valid[k+1]),
            .o_data    (c_data[k+1])
        );
    end

    // The writer forms P1 from q and the divider when it loads a setting and
    // then walks the eight parameter writes and the control write.
    mfre_writer u_writer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[N_CELLS]),
        .i_data  (c_data[N_CELLS]),
        .o_take  (take),
        .o_wr    (o_wr)
    );

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[N_CELLS] |-> (c_data[N_CELLS].rem < c_data[N_CELLS].den))
        else $error("division remainder not below the denominator");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> c_valid[N_CELLS])
        else $error("request stalled while the chain end is empty");

    a_drop_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && !item_ok) |=> !c_valid[1])
        else $error("out-of-range setting entered the divider chain");

endmodule

@@ tb/tb_multisynth_fraction_register_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the fractional output divider register encoder
// Sends divider settings (a directed stimulus table, then random settings)
// with random gaps and output back-pressure. Every register write that comes
// out is checked field by field against writes predicted from the setting.
// ----------------------------------------------------------------------------
module tb_multisynth_fraction_register_encoder_top;

    import mfre_pkg::*;

    // Run length and timing limits. The worst legal run is about 500 settings
    // times nine writes, each waiting out the longest output stall, so the
    // watchdog sits several times above that.
    localparam int RANDOM_SETTINGS = 470;
    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AT_SETTING = 40;

    // One divider setting as offered on the request channel.
    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic              pll;
        logic [DIV_W-1:0]  div;
        logic [FRAC_W-1:0] num;
        logic [FRAC_W-1:0] den;
    } t_setting;

    // One register write as seen on the write channel.
    typedef struct {
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } t_reg_write;

    // How a row of the directed stimulus table is checked: against the
    // predictor, against nine bytes typed into the row, or as a setting
    // that the block must drop without any write.
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_TYPED,
        ROW_REJECTED
    } t_row_kind;

    typedef struct {
        t_setting   setting;
        t_row_kind  kind;
        logic [7:0] base;
        logic [71:0] bytes;     // eight divider bytes, then the control byte
        logic [7:0] ctrl_addr;
    } t_stim_row;

    logic clk;
    logic rst_n;

    mfre_req_if req_bus ();
    mfre_wr_if  wr_bus ();

    multisynth_fraction_register_encoder_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus.sink),
        .o_wr    (wr_bus.source)
    );

    // Writes still owed by the block, oldest first.
    t_reg_write pending_writes[$];
    t_stim_row  stim_rows[$];

    int cycle_count       = 0;
    int fail_count        = 0;
    int settings_sent     = 0;
    int settings_rejected = 0;
    int writes_checked    = 0;
    bit hold_request      = 1'b0;

    // ------------------------------------------------------------------------
    // Clock and cycle counter. The counter feeds the watchdog below.
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a run that has not finished by the limit has hung somewhere,
    // most likely a lost write or a request channel that never frees up.
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("%0t: timeout after %0d cycles, %0d writes still pending",
                 $time, cycle_count, pending_writes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor. Works out the divider parameters with an exact integer
    // quotient, then queues the nine writes in the order the device expects.
    // Returns the number of writes queued; a setting outside the legal range
    // queues none.
    // ------------------------------------------------------------------------
    function automatic int predict_writes(input t_setting s);
        longint unsigned   scaled;
        longint unsigned   quo;
        longint unsigned   p1_full;
        logic [P1_W-1:0]   p1;
        logic [FRAC_W-1:0] p2;
        logic [FRAC_W-1:0] p3;
        logic [7:0]        base;
        logic [7:0]        ctrl;
        logic [7:0]        bytes [8];
        if (s.idx > IDX_MAX || s.div < DIV_MIN || s.div > DIV_MAX || s.den == '0) begin
            return 0;
        end
        scaled  = longint'(s.num) << SCALE_W;
        quo     = scaled / longint'(s.den);
        p1_full = (longint'(s.div) << SCALE_W) + quo - longint'(P1_OFFSET);
        p1      = p1_full[P1_W-1:0];
        p2      = FRAC_W'(scaled - quo * longint'(s.den));
        p3      = s.den;
        case (s.idx)
            2'd0: begin
                base = BASE_OUT0;
            end
            2'd1: begin
                base = BASE_OUT1;
            end
            default: begin
                base = BASE_OUT2;
            end
        endcase
        bytes = '{p3[15:8], p3[7:0], {6'b0, p1[17:16]}, p1[15:8], p1[7:0],
                  {p3[19:16], p2[19:16]}, p2[15:8], p2[7:0]};
        for (int k = 0; k < 8; k++) begin
            pending_writes.push_back('{8'(base + k), bytes[k], 1'b0});
        end
        ctrl = s.pll ? CTRL_PLLB : CTRL_PLLA;
        if (s.num == '0) begin
            ctrl = ctrl | CTRL_INT_MODE;
        end
        pending_writes.push_back('{8'(CTRL_REG_BASE + s.idx), ctrl, 1'b1});
        return 9;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic t_stim_row mk_row(input logic [1:0] idx, input logic pll,
                                         input logic [9:0] div, input logic [19:0] num,
                                         input logic [19:0] den, input t_row_kind kind,
                                         input logic [7:0] base, input logic [71:0] bytes,
                                         input logic [7:0] ctrl_addr);
        t_stim_row r;
        r.setting   = '{idx, pll, div, num, den};
        r.kind      = kind;
        r.base      = base;
        r.bytes     = bytes;
        r.ctrl_addr = ctrl_addr;
        return r;
    endfunction

    // Gap lengths: drawn from three ranges, the shortest most often, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 70);
    endfunction

    // Random setting. About one in ten is out of range in one of the ways
    // the block must drop; the rest are legal with a bias toward the edges.
    function automatic t_setting random_setting();
        t_setting s;
        int       r;
        s.idx = 2'($urandom_range(0, 2));
        s.pll = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        s.div = (r < 10) ? DIV_MIN : (r < 20) ? DIV_MAX : 10'($urandom_range(4, 900));
        r = $urandom_range(0, 99);
        s.den = (r < 15) ? 20'($urandom_range(1, 16)) :
                (r < 25) ? 20'hFFFFF : 20'($urandom_range(1, 20'hFFFFF));
        r = $urandom_range(0, 99);
        s.num = (r < 10) ? 20'd0 :
                (r < 25) ? 20'($urandom_range(0, s.den - 1)) :
                (r < 35) ? 20'hFFFFF : 20'($urandom());
        if ($urandom_range(0, 99) < 10) begin
            case ($urandom_range(0, 3))
                0: begin
                    s.idx = 2'd3;
                end
                1: begin
                    s.div = 10'($urandom_range(0, 3));
                end
                2: begin
                    s.div = 10'($urandom_range(901, 1023));
                end
                default: begin
                    s.den = '0;
                end
            endcase
        end
        return s;
    endfunction

    // Offers one setting and returns at the edge where it is accepted. With
    // a zero gap valid simply stays high and the payload changes, so valid is
    // never lowered and raised in the same time step.
    task automatic offer_setting(input t_setting s, input int gap);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.output_index <= s.idx;
        req_bus.pll_source   <= s.pll;
        req_bus.divider      <= s.div;
        req_bus.numerator    <= s.num;
        req_bus.denominator  <= s.den;
        do @(posedge clk); while (!req_bus.ready);
        settings_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Write receiver and checker. It samples the channel at each rising edge,
    // before any of that edge's updates land, and then picks ready for the
    // next cycle. Ready gets exactly one assignment per edge.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %02h, actual %02h",
                     $time, name, exp_val, act_val);
        end
    endfunction

    initial begin
        t_reg_write exp_wr;
        int         hold_left;
        int         idle_left;
        int         free_left;
        hold_left = 0;
        idle_left = 0;
        free_left = 0;
        wr_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (wr_bus.valid && wr_bus.ready) begin
                if (pending_writes.size() == 0) begin
                    fail_count++;
                    $display({"%0t: unexpected write, expected none, ",
                              "actual addr %02h data %02h last %0d"},
                             $time, wr_bus.reg_address, wr_bus.reg_data,
                             wr_bus.last_write);
                end else begin
                    exp_wr = pending_writes.pop_front();
                    check_field("reg_address", exp_wr.addr, wr_bus.reg_address);
                    check_field("reg_data", exp_wr.data, wr_bus.reg_data);
                    check_field("last_write", 8'(exp_wr.last), 8'(wr_bus.last_write));
                    writes_checked++;
                end
            end
            // A long hold-off asked for by the stimulus fills the divider
            // chain and must push back on the request channel.
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                wr_bus.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                wr_bus.ready <= 1'b0;
            end else begin
                wr_bus.ready <= 1'b1;
                if (free_left > 0) begin
                    free_left--;
                end else if ($urandom_range(0, 99) < 3) begin
                    free_left = $urandom_range(50, 200);
                end else if ($urandom_range(0, 99) < 30) begin
                    idle_left = pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random settings, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin
        t_stim_row row;
        t_setting  s;
        int        queued;
        int        burst_left;
        int        gap;

        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.output_index = '0;
        req_bus.pll_source   = 1'b0;
        req_bus.divider      = '0;
        req_bus.numerator    = '0;
        req_bus.denominator  = '0;
        burst_left           = 0;

        // Rows with typed results are the ones whose bytes follow directly:
        // the range extremes, and the case of a numerator far above the
        // denominator where P1 wraps within its 18 bits.
        stim_rows.push_back(mk_row(2'd0, 1'b0, 10'd4, 20'd0, 20'd1, ROW_TYPED,
                                   8'd42, 72'h00_01_00_00_00_00_00_00_4F, 8'd16));
        stim_rows.push_back(mk_row(2'd2, 1'b1, 10'd900, 20'd0, 20'hFFFFF, ROW_TYPED,
                                   8'd58, 72'hFF_FF_01_C0_00_F0_00_00_6F, 8'd18));
        stim_rows.push_back(mk_row(2'd1, 1'b0, 10'd4, 20'hFFFFF, 20'd1, ROW_TYPED,
                                   8'd50, 72'h00_01_03_FF_80_00_00_00_0F, 8'd17));
        stim_rows.push_back(mk_row(2'd0, 1'b1, 10'd900, 20'hFFFFF, 20'hFFFFF, ROW_TYPED,
                                   8'd42, 72'hFF_FF_01_C0_80_F0_00_00_2F, 8'd16));
        // Out-of-range settings: dropped with no write at all.
        stim_rows.push_back(mk_row(2'd0, 1'b0, 10'd3, 20'd5, 20'd7,
                                   ROW_REJECTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd1, 1'b1, 10'd901, 20'd5, 20'd7,
                                   ROW_REJECTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd2, 1'b0, 10'd0, 20'd5, 20'd7,
                                   ROW_REJECTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd0, 1'b1, 10'd1023, 20'hFFFFF, 20'hFFFFF,
                                   ROW_REJECTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd1, 1'b0, 10'd100, 20'd9, 20'd0,
                                   ROW_REJECTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd3, 1'b1, 10'd100, 20'd1, 20'd3,
                                   ROW_REJECTED, '0, '0, '0));
        // Ordinary fractions, checked against the predictor.
        stim_rows.push_back(mk_row(2'd0, 1'b1, 10'd5, 20'd1, 20'd3,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd1, 1'b1, 10'd100, 20'd2, 20'd3,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd2, 1'b0, 10'd512, 20'h7FFFF, 20'hFFFFF,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd0, 1'b0, 10'd899, 20'hFFFFE, 20'hFFFFF,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd1, 1'b0, 10'd37, 20'd1, 20'd2,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd2, 1'b1, 10'd6, 20'h12345, 20'h6789A,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd0, 1'b1, 10'd777, 20'hFFFFF, 20'h10,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd1, 1'b1, 10'd4, 20'd1, 20'hFFFFF,
                                   ROW_PREDICTED, '0, '0, '0));
        stim_rows.push_back(mk_row(2'd2, 1'b0, 10'd450, 20'hABCDE, 20'hFFFFF,
                                   ROW_PREDICTED, '0, '0, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Expectations are queued at the accepting edge, long
        // before the first write of that setting can come out.
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            offer_setting(row.setting, ($urandom_range(0, 1) == 0) ? 0 : pick_gap());
            case (row.kind)
                ROW_TYPED: begin
                    for (int k = 0; k < 8; k++) begin
                        pending_writes.push_back('{8'(row.base + k),
                                                   row.bytes[71 - 8 * k -: 8], 1'b0});
                    end
                    pending_writes.push_back('{row.ctrl_addr, row.bytes[7:0], 1'b1});
                end
                ROW_REJECTED: begin
                    settings_rejected++;
                end
                default: begin
                    if (predict_writes(row.setting) == 0) begin
                        settings_rejected++;
                    end
                end
            endcase
        end

        // Random part. Runs of back-to-back settings alternate with gaps; at
        // one point the receiver holds off while a long burst keeps coming.
        for (int n = 0; n < RANDOM_SETTINGS; n++) begin
            if (n == HOLD_AT_SETTING) begin
                hold_request = 1'b1;
                burst_left   = 80;
            end
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                if ($urandom_range(0, 99) < 4) begin
                    burst_left = $urandom_range(10, 30);
                end
                gap = ($urandom_range(0, 99) < 50) ? 0 : pick_gap();
            end
            s = random_setting();
            offer_setting(s, gap);
            queued = predict_writes(s);
            if (queued == 0) begin
                settings_rejected++;
            end
        end
        req_bus.valid <= 1'b0;

        // Drain: wait for every owed write, then give the chain time to show
        // any stray write before the verdict.
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d settings (%0d dropped as out of range) and %0d checked",
                 settings_sent, settings_rejected, writes_checked);
        $display("writes, with random gaps on both channels and one long output hold-off.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
